// ===== design/csds_pkg.sv =====
// Shared types, constants and constant tables of the Collatz survival depth scan.
package csds_pkg;

	localparam int MAX_STEPS = 256;
	localparam int BLOCK_LEN = 8;
	localparam int NPAT      = 1 << BLOCK_LEN;
	localparam int MASK_W    = 40;
	localparam int MBITS_W   = 6;
	localparam int DEPTH_W   = 9;
	localparam int Q_W       = $clog2(MAX_STEPS + 1);
	localparam int OFF_W     = $clog2(BLOCK_LEN);
	localparam int CNT_W     = 41;
	localparam int P_W       = MAX_STEPS + 4;

	localparam logic [MBITS_W-1:0] MBITS_RESET = 6'd27;
	localparam logic [DEPTH_W-1:0] DEPTH_T128  = 9'd128;
	localparam logic [DEPTH_W-1:0] DEPTH_T160  = 9'd160;
	localparam logic [DEPTH_W-1:0] DEPTH_T192  = 9'd192;

	typedef logic [MAX_STEPS:0][Q_W-1:0] min_odd_tab_t;
	typedef logic [NPAT-1:0] blk_tab_t;

	typedef struct packed {
		logic               idle;
		logic               done;
		logic [DEPTH_W-1:0] depth;
	} eng_status_t;

	// least q with 3^q >= 2^k for every k
	function automatic min_odd_tab_t build_min_odd();
		min_odd_tab_t   tab;
		logic [P_W-1:0] p;
		int             q;
		p = P_W'(1);
		q = 0;
		tab[0] = '0;
		for (int k = 1; k <= MAX_STEPS; k++) begin
			while ((p >> k) == '0) begin
				p = p + (p << 1);
				q++;
			end
			tab[k] = Q_W'(q);
		end
		return tab;
	endfunction

	// reduce v modulo md by shifted subtraction
	function automatic longint unsigned residue(input longint unsigned v,
			input longint unsigned md);
		longint unsigned r;
		r = v;
		for (int s = 24; s >= 0; s--) begin
			if (r >= (md << s))
				r = r - (md << s);
		end
		return r;
	endfunction

	// parity patterns whose residue value is largest in their class mod 3^weight
	function automatic blk_tab_t build_blk_ok();
		blk_tab_t          tab;
		longint unsigned   rv [NPAT];
		int                wt [NPAT];
		longint unsigned   p3 [BLOCK_LEN+1];
		longint unsigned   r;
		longint unsigned   md;
		int                w;
		logic              ok;
		p3[0] = 1;
		for (int i = 1; i <= BLOCK_LEN; i++)
			p3[i] = 3 * p3[i-1];
		for (int a = 0; a < NPAT; a++) begin
			r = 0;
			w = 0;
			for (int i = 0; i < BLOCK_LEN; i++) begin
				if (((a >> i) & 1) != 0) begin
					r = 3 * r + (64'd1 << i);
					w++;
				end
			end
			rv[a] = r;
			wt[a] = w;
		end
		for (int a = 0; a < NPAT; a++) begin
			ok = 1'b1;
			md = p3[wt[a]];
			for (int b = 0; b < NPAT; b++) begin
				if (b != a && wt[b] == wt[a] && residue(rv[b], md) == residue(rv[a], md)) begin
					if (rv[b] > rv[a] || (rv[b] == rv[a] && b < a))
						ok = 1'b0;
				end
			end
			tab[a] = ok;
		end
		return tab;
	endfunction

	localparam min_odd_tab_t MIN_ODD = build_min_odd();
	localparam blk_tab_t     BLK_OK  = build_blk_ok();

endpackage

// ===== design/csds_engine.sv =====
// Start value build and accelerated Collatz run on one shared adder.
module csds_engine #(
	parameter int VALUE_WIDTH = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [csds_pkg::MASK_W-1:0]      mask,
	input  logic [csds_pkg::MBITS_W-1:0]     mask_bits,
	input  logic                             ack,
	output csds_pkg::eng_status_t            status
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BUILD = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                          state_q;
	logic [VALUE_WIDTH-1:0]              x_q;
	logic [csds_pkg::MASK_W-1:0]         mask_q;
	logic [csds_pkg::MBITS_W-1:0]        idx_q;
	logic                                first_q;
	logic [csds_pkg::DEPTH_W-1:0]        k_q;
	logic [csds_pkg::Q_W-1:0]            q_q;
	logic [csds_pkg::BLOCK_LEN-1:0]      pat_q;
	logic [csds_pkg::OFF_W-1:0]          off_q;
	logic [csds_pkg::DEPTH_W-1:0]        depth_q;

	logic                                build_bit;
	logic                                cin;
	logic [VALUE_WIDTH-1:0]              sum;
	logic                                odd;
	logic [csds_pkg::Q_W-1:0]            q_nx;
	logic [csds_pkg::BLOCK_LEN-1:0]      pat_nx;
	logic                                blk_end;
	logic [csds_pkg::DEPTH_W-1:0]        k_nx;
	logic                                fail;
	logic                                k_last;

	assign build_bit = first_q ? 1'b1 :
		((idx_q < csds_pkg::MBITS_W'(csds_pkg::MASK_W)) ? mask_q[idx_q] : 1'b0);
	assign cin = (state_q == ST_BUILD) ? build_bit : 1'b1;
	assign sum = x_q + {x_q[VALUE_WIDTH-2:0], 1'b0} + VALUE_WIDTH'(cin);

	assign odd     = x_q[0];
	assign q_nx    = q_q + csds_pkg::Q_W'(odd);
	assign pat_nx  = pat_q | (csds_pkg::BLOCK_LEN'(odd) << off_q);
	assign blk_end = (off_q == csds_pkg::OFF_W'(csds_pkg::BLOCK_LEN - 1));
	assign k_nx    = k_q + 1'b1;
	assign fail    = (q_nx < csds_pkg::MIN_ODD[k_nx]) ||
		(blk_end && !csds_pkg::BLK_OK[pat_nx]);
	assign k_last  = (k_q == csds_pkg::DEPTH_W'(csds_pkg::MAX_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (start) state_q <= ST_BUILD;
				ST_BUILD: if (idx_q == '0) state_q <= ST_RUN;
				ST_RUN:   if (fail || k_last) state_q <= ST_DONE;
				ST_DONE:  if (ack) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					x_q     <= '0;
					mask_q  <= mask;
					idx_q   <= mask_bits;
					first_q <= 1'b1;
					k_q     <= '0;
					q_q     <= '0;
					pat_q   <= '0;
					off_q   <= '0;
				end
			end
			ST_BUILD: begin
				first_q <= 1'b0;
				idx_q   <= idx_q - 1'b1;
				if (idx_q == '0)
					x_q <= {sum[VALUE_WIDTH-3:0], 2'b11};
				else
					x_q <= sum;
			end
			ST_RUN: begin
				x_q <= odd ? (sum >> 1) : (x_q >> 1);
				q_q <= q_nx;
				k_q <= k_nx;
				if (blk_end) begin
					pat_q <= '0;
					off_q <= '0;
				end else begin
					pat_q <= pat_nx;
					off_q <= off_q + 1'b1;
				end
				if (fail)
					depth_q <= k_q;
				else if (k_last)
					depth_q <= csds_pkg::DEPTH_W'(csds_pkg::MAX_STEPS);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign status.idle  = (state_q == ST_IDLE);
	assign status.done  = (state_q == ST_DONE);
	assign status.depth = depth_q;

endmodule

// ===== design/collatz_survival_depth_scan_core.sv =====
// Top level of the Collatz survival depth scan: handshakes, counters, result register.
//
// channel | direction | handshake            | payload
// s_*     | in        | s_tvalid / s_tready  | s_tdata: start_mask
// m_*     | out       | m_tvalid / m_tready  | m_tdata: depth, flags, totals, deepest
// cfg_*   | in        | cfg_valid / cfg_ready| cfg_data: mask_bits
//
// One request first builds the start value (from m = mask_bits mask bits), then runs
// one Collatz step per cycle up to 256 steps, then hands the result over and returns
// to idle before the next request; the engine takes no new request until then, as the
// single adder serves both phases.
// Reset clears the counters, the deepest depth, mask_bits (to 27) and all handshakes.
// s_tready is high only while the engine is idle; a result waiting on m_tready
// does not block a new request, but the engine holds its result until the
// output register is free.
module collatz_survival_depth_scan_core #(
	parameter int VALUE_WIDTH = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // [39:0] start_mask
	output logic         m_tvalid,
	input  logic         m_tready,
	// [8:0] depth, [9] reached_128, [10] reached_160, [11] reached_192,
	// [52:12] total_128, [93:53] total_160, [134:94] total_192, [143:135] deepest
	output logic [143:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [5:0]   cfg_data
);

	logic [csds_pkg::MBITS_W-1:0]  mask_bits_q;
	csds_pkg::eng_status_t         status;
	logic                          start;
	logic                          out_load;
	logic                          r128;
	logic                          r160;
	logic                          r192;

	logic                          m_tvalid_q;
	logic [csds_pkg::DEPTH_W-1:0]  depth_q;
	logic                          r128_q;
	logic                          r160_q;
	logic                          r192_q;
	logic [csds_pkg::CNT_W-1:0]    total_128_q;
	logic [csds_pkg::CNT_W-1:0]    total_160_q;
	logic [csds_pkg::CNT_W-1:0]    total_192_q;
	logic [csds_pkg::DEPTH_W-1:0]  deepest_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = status.idle;
	assign start     = s_tvalid && s_tready;
	assign out_load  = status.done && (!m_tvalid_q || m_tready);

	assign r128 = (status.depth >= csds_pkg::DEPTH_T128);
	assign r160 = (status.depth >= csds_pkg::DEPTH_T160);
	assign r192 = (status.depth >= csds_pkg::DEPTH_T192);

	csds_engine #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.mask     (s_tdata),
		.mask_bits(mask_bits_q),
		.ack      (out_load),
		.status   (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_bits_q <= csds_pkg::MBITS_RESET;
			m_tvalid_q  <= 1'b0;
			total_128_q <= '0;
			total_160_q <= '0;
			total_192_q <= '0;
			deepest_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				mask_bits_q <= cfg_data;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				if (r128) total_128_q <= total_128_q + 1'b1;
				if (r160) total_160_q <= total_160_q + 1'b1;
				if (r192) total_192_q <= total_192_q + 1'b1;
				if (status.depth > deepest_q) deepest_q <= status.depth;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			depth_q <= status.depth;
			r128_q  <= r128;
			r160_q  <= r160;
			r192_q  <= r192;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {deepest_q, total_192_q, total_160_q, total_128_q,
		r192_q, r160_q, r128_q, depth_q};

`ifndef ASSERT_OFF
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_tready)
		else $error("engine took a request while busy");

	a_deepest_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> deepest_q >= $past(deepest_q))
		else $error("deepest depth decreased");

	a_flags_nested: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> ((!r192_q || r160_q) && (!r160_q || r128_q)))
		else $error("threshold flags inconsistent");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> depth_q <= csds_pkg::DEPTH_W'(csds_pkg::MAX_STEPS))
		else $error("depth beyond step limit");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (total_128_q == $past(total_128_q)) ||
			(total_128_q == $past(total_128_q) + 1'b1))
		else $error("count advanced by more than one");
`endif

endmodule

// ===== bench/csds_checker.sv =====
`timescale 1ns / 100ps
// Checker for the depth scan: watches the channels, predicts each report and compares it.
module csds_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [csds_pkg::MASK_W-1:0]     s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [143:0]                    m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [csds_pkg::MBITS_W-1:0]    cfg_data,
	output int                              errors,
	output int                              received,
	output logic [csds_pkg::DEPTH_W-1:0]    deepest_seen
);
	import csds_pkg::*;

	localparam int VALUE_W = 128;

	typedef struct packed {
		logic [DEPTH_W-1:0] deepest;
		logic [CNT_W-1:0]   total_192, total_160, total_128;
		logic               reached_192, reached_160, reached_128;
		logic [DEPTH_W-1:0] depth;
	} scan_report_t;

	int                 odd_floor [0:MAX_STEPS];
	bit                 allowed_pat [0:NPAT-1];
	logic [MBITS_W-1:0] width;
	logic [CNT_W-1:0]   hits_128, hits_160, hits_192;
	logic [DEPTH_W-1:0] depth_now;
	scan_report_t       report_q [$];
	scan_report_t       want, got;

	initial begin
		logic [P_W-1:0]  pow3;
		longint unsigned resid [NPAT];
		int              weight [NPAT];
		longint unsigned modulus;
		int              q;
		pow3 = P_W'(1);
		q = 0;
		odd_floor[0] = 0;
		for (int k = 1; k <= MAX_STEPS; k++) begin
			while (pow3 < (P_W'(1) << k)) begin
				pow3 = pow3 * 3;
				q++;
			end
			odd_floor[k] = q;
		end
		for (int a = 0; a < NPAT; a++) begin
			resid[a] = 0;
			weight[a] = 0;
			for (int i = 0; i < BLOCK_LEN; i++) begin
				if (((a >> i) & 1) != 0) begin
					resid[a] = 3 * resid[a] + (64'd1 << i);
					weight[a]++;
				end
			end
		end
		for (int a = 0; a < NPAT; a++) begin
			modulus = 1;
			for (int j = 0; j < weight[a]; j++)
				modulus = modulus * 3;
			allowed_pat[a] = 1'b1;
			for (int b = 0; b < NPAT; b++) begin
				if (b != a && weight[b] == weight[a]
						&& resid[b] % modulus == resid[a] % modulus
						&& (resid[b] > resid[a] || (resid[b] == resid[a] && b < a)))
					allowed_pat[a] = 1'b0;
			end
		end
	end

	function automatic logic [VALUE_W-1:0] start_value(input logic [MASK_W-1:0] mask,
			input logic [MBITS_W-1:0] m);
		logic [VALUE_W-1:0] acc;
		logic [VALUE_W-1:0] pow3;
		acc = '0;
		pow3 = VALUE_W'(1);
		for (int i = 0; i <= int'(m); i++) begin
			if (i == int'(m) || (i < MASK_W && mask[i]))
				acc = acc + pow3;
			pow3 = pow3 * 3;
		end
		return (acc << 2) + 3;
	endfunction

	function automatic int walk_depth(input logic [VALUE_W-1:0] start);
		logic [VALUE_W-1:0]   x;
		logic [BLOCK_LEN-1:0] pattern;
		int                   odd_steps;
		int                   offset;
		x = start;
		pattern = '0;
		odd_steps = 0;
		offset = 0;
		for (int k = 0; k < MAX_STEPS; k++) begin
			pattern[offset] = x[0];
			offset++;
			if (x[0]) begin
				x = x * 3 + 1;
				odd_steps++;
			end
			x = x >> 1;
			if (odd_steps < odd_floor[k + 1])
				return k;
			if (offset == BLOCK_LEN) begin
				if (!allowed_pat[pattern])
					return k;
				pattern = '0;
				offset = 0;
			end
		end
		return MAX_STEPS;
	endfunction

	task automatic check_field(input string field, input logic [CNT_W-1:0] exp_val,
			input logic [CNT_W-1:0] got_val);
		if (exp_val !== got_val) begin
			errors++;
			if (errors <= 10)
				$display("checker: report %0d %s expected %0d got %0d",
					received, field, exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width = MBITS_RESET;
			hits_128 = '0;
			hits_160 = '0;
			hits_192 = '0;
			deepest_seen = '0;
			errors = 0;
			report_q.delete();
			received <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				depth_now = DEPTH_W'(walk_depth(start_value(s_tdata, width)));
				if (depth_now >= DEPTH_T128)
					hits_128 = hits_128 + 1'b1;
				if (depth_now >= DEPTH_T160)
					hits_160 = hits_160 + 1'b1;
				if (depth_now >= DEPTH_T192)
					hits_192 = hits_192 + 1'b1;
				if (depth_now > deepest_seen)
					deepest_seen = depth_now;
				want.depth = depth_now;
				want.reached_128 = depth_now >= DEPTH_T128;
				want.reached_160 = depth_now >= DEPTH_T160;
				want.reached_192 = depth_now >= DEPTH_T192;
				want.total_128 = hits_128;
				want.total_160 = hits_160;
				want.total_192 = hits_192;
				want.deepest = deepest_seen;
				report_q.push_back(want);
			end
			if (cfg_valid && cfg_ready)
				width = cfg_data;
			if (m_tvalid && m_tready) begin
				received <= received + 1;
				got = m_tdata;
				if (report_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("checker: report %0d arrived with no request pending, data %h",
							received, m_tdata);
				end else begin
					want = report_q.pop_front();
					check_field("depth", CNT_W'(want.depth), CNT_W'(got.depth));
					check_field("reached_128", CNT_W'(want.reached_128),
						CNT_W'(got.reached_128));
					check_field("reached_160", CNT_W'(want.reached_160),
						CNT_W'(got.reached_160));
					check_field("reached_192", CNT_W'(want.reached_192),
						CNT_W'(got.reached_192));
					check_field("total_128", want.total_128, got.total_128);
					check_field("total_160", want.total_160, got.total_160);
					check_field("total_192", want.total_192, got.total_192);
					check_field("deepest", CNT_W'(want.deepest), CNT_W'(got.deepest));
				end
			end
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the depth scan bench: clock, reset, start mask and width stimulus, verdict.
module testbench;
	import csds_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int TAIL_CYCLES = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [MASK_W-1:0]  s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [143:0]       m_tdata;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [MBITS_W-1:0] cfg_data = '0;

	int                 errors;
	int                 received;
	logic [DEPTH_W-1:0] deepest_seen;

	int sent = 0;
	int widths_used = 0;
	int cycles = 0;
	int tx_gap = 0;
	bit tx_calm = 1'b0;
	int rx_stall = 0;
	int rx_draw;
	bit rx_calm = 1'b0;

	collatz_survival_depth_scan_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	csds_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.received     (received),
		.deepest_seen (deepest_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// after each accepted report, hold m_tready low for a random stall counted down while a report is offered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall <= 0;
		end else if (m_tready && m_tvalid) begin
			if ($urandom_range(0, 15) == 0)
				rx_calm = !rx_calm;
			rx_draw = rx_calm ? 0 : $urandom_range(0, 15);
			m_tready <= (rx_draw == 0);
			rx_stall <= rx_draw;
		end else if (!m_tready && (m_tvalid || rx_stall == 0)) begin
			if (rx_stall <= 1)
				m_tready <= 1'b1;
			rx_stall <= rx_stall - 1;
		end
	end

	task automatic send_mask(input logic [MASK_W-1:0] mask, input bit last);
		if (tx_gap > 0)
			repeat (tx_gap) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= mask;
		do @(posedge clk); while (!s_tready);
		sent++;
		if ($urandom_range(0, 15) == 0)
			tx_calm = !tx_calm;
		tx_gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (last || tx_gap > 0)
			s_tvalid <= 1'b0;
	endtask

	task automatic write_width(input logic [MBITS_W-1:0] w);
		while (received < sent) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		widths_used++;
	endtask

	initial begin
		logic [MBITS_W-1:0] w;
		logic [MASK_W-1:0]  mask;
		int                 count;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_mask(40'h0, 1'b0);
		send_mask(40'hFF_FFFF_FFFF, 1'b0);
		send_mask(40'h1, 1'b0);
		send_mask(40'h1 << 26, 1'b0);
		send_mask(40'h1 << 27, 1'b0);
		send_mask(40'h55_5555_5555, 1'b0);
		send_mask(40'hAA_AAAA_AAAA, 1'b0);
		send_mask(40'h00_07FF_FFFF, 1'b1);
		write_width(6'd0);
		send_mask(40'h0, 1'b0);
		send_mask(40'hFF_FFFF_FFFF, 1'b1);
		write_width(6'd63);
		send_mask(40'h0, 1'b0);
		send_mask(40'hFF_FFFF_FFFF, 1'b0);
		send_mask(MASK_W'({$urandom, $urandom}), 1'b1);
		write_width(6'd40);
		send_mask(40'hFF_FFFF_FFFF, 1'b0);
		send_mask(40'h1 << 39, 1'b1);
		write_width(6'd41);
		send_mask(40'hFF_FFFF_FFFF, 1'b1);

		for (int p = 0; p < 12; p++) begin
			case (p)
				0: w = 6'd63;
				1: w = 6'd0;
				2: w = 6'd1;
				3: w = 6'd40;
				4: w = 6'd41;
				5: w = 6'd2;
				default: w = MBITS_W'($urandom_range(3, 63));
			endcase
			write_width(w);
			count = (w < 3) ? 20 : 130;
			for (int i = 0; i < count; i++) begin
				mask = MASK_W'({$urandom, $urandom});
				case ($urandom_range(0, 7))
					0: mask = mask & MASK_W'({$urandom, $urandom});
					1: mask = mask | MASK_W'({$urandom, $urandom});
					default: ;
				endcase
				send_mask(mask, i == count - 1);
			end
		end

		while (received < sent) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("testbench: %0d start masks scanned under %0d mask widths, %0d reports checked",
			sent, widths_used, received);
		$display("testbench: deepest survival depth %0d, %0d field mismatches",
			deepest_seen, errors);
		if (errors == 0 && received == sent)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
